// ===== rtl/core/masked_address_access_check_assert.svh =====
// masked_address_access_check_assert.svh: assertion macros for the access check block
// used by the port checker; needs no other file
`ifndef MASKED_ADDRESS_ACCESS_CHECK_ASSERT_SVH
`define MASKED_ADDRESS_ACCESS_CHECK_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define MAC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("access check assertion failed");

// next-cycle implication, disabled while reset is low
`define MAC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("access check assertion failed");

`endif

// ===== rtl/core/mac_pkg.sv =====
`timescale 1ns / 1ps
// mac_pkg: widths, codes and shared types of the masked address access check
// no dependencies
package mac_pkg;

    localparam int ENTRIES_DEFAULT = 16;
    localparam int ADDR_W          = 16;
    localparam int INDEX_W         = 4;
    localparam int COUNT_W         = 5;
    localparam int APB_ADDR_W      = 2;
    localparam int APB_DATA_W      = 32;

    // command codes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_CHECK = 1'b1;

    // register byte addresses
    localparam logic [APB_ADDR_W-1:0] REG_RULE_COUNT = '0;

    // one stored rule
    typedef struct packed {
        logic [ADDR_W-1:0] src_value;
        logic [ADDR_W-1:0] src_mask;
        logic [ADDR_W-1:0] dst_value;
        logic [ADDR_W-1:0] dst_mask;
        logic              check_dest;
        logic              grant;
    } rule_t;

    // packet token walking down the chain with its verdict so far
    typedef struct packed {
        logic               valid;
        logic [ADDR_W-1:0]  src;
        logic [ADDR_W-1:0]  dst;
        logic               matched;
        logic               grant;
        logic [INDEX_W-1:0] index;
    } token_t;

    // control from the top level to the chain
    typedef struct packed {
        logic               advance;
        logic               wr_en;
        logic [INDEX_W-1:0] wr_index;
    } chain_ctrl_t;

endpackage

// ===== rtl/core/mac_if.sv =====
`timescale 1ns / 1ps
// mac_if: request and response channel interfaces of the access check
// depends on mac_pkg
interface mac_req_if;
    logic                           valid;
    logic                           ready;
    logic                           command;
    logic [mac_pkg::INDEX_W-1:0]    rule_index;
    logic [mac_pkg::ADDR_W-1:0]     rule_source;
    logic [mac_pkg::ADDR_W-1:0]     rule_source_mask;
    logic [mac_pkg::ADDR_W-1:0]     rule_dest;
    logic [mac_pkg::ADDR_W-1:0]     rule_dest_mask;
    logic                           rule_check_dest;
    logic                           rule_grant;
    logic [mac_pkg::ADDR_W-1:0]     packet_source;
    logic [mac_pkg::ADDR_W-1:0]     packet_dest;

    modport source (
        output valid, command, rule_index, rule_source, rule_source_mask, rule_dest,
               rule_dest_mask, rule_check_dest, rule_grant, packet_source, packet_dest,
        input  ready
    );
    modport sink (
        input  valid, command, rule_index, rule_source, rule_source_mask, rule_dest,
               rule_dest_mask, rule_check_dest, rule_grant, packet_source, packet_dest,
        output ready
    );
endinterface

interface mac_rsp_if;
    logic                           valid;
    logic                           ready;
    logic                           permitted;
    logic                           matched;
    logic [mac_pkg::INDEX_W-1:0]    match_index;

    modport source (
        output valid, permitted, matched, match_index,
        input  ready
    );
    modport sink (
        input  valid, permitted, matched, match_index,
        output ready
    );
endinterface

// ===== rtl/core/mac_cell.sv =====
`timescale 1ns / 1ps
// mac_cell: one rule slot of the chain, compares the passing token against its rule
// depends on mac_pkg
module mac_cell #(
    parameter int ENTRIES    = mac_pkg::ENTRIES_DEFAULT,
    parameter int CELL_INDEX = 0
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  mac_pkg::chain_ctrl_t         ctrl,
    input  mac_pkg::rule_t               wr_rule,
    input  logic [mac_pkg::COUNT_W-1:0]  rule_count,
    input  mac_pkg::token_t              token_in,
    output mac_pkg::token_t              token_out
);

    localparam int POS_W = $clog2(ENTRIES + 1);
    localparam int CMP_W = ((POS_W > mac_pkg::COUNT_W) ? POS_W : mac_pkg::COUNT_W) + 1;
    localparam logic [CMP_W-1:0] MY_POS = CMP_W'(CELL_INDEX);

    mac_pkg::rule_t  rule_reg;
    mac_pkg::token_t token_reg;
    mac_pkg::token_t token_next;
    logic            wr_hit;
    logic            active;
    logic            src_hit;
    logic            dst_hit;
    logic            hit;

    // write decode against this slot's position
    assign wr_hit = ctrl.wr_en && (CMP_W'(ctrl.wr_index) == MY_POS);

    // slot takes part only below the programmed count
    assign active = CMP_W'(rule_count) > MY_POS;

    // masked compares
    assign src_hit = (token_in.src & ~rule_reg.src_mask) == rule_reg.src_value;
    assign dst_hit = (token_in.dst & ~rule_reg.dst_mask) == rule_reg.dst_value;
    assign hit     = active && src_hit && (!rule_reg.check_dest || dst_hit);

    // first hit wins, later slots pass the verdict on
    always_comb
    begin
        token_next = token_in;
        if (token_in.valid && !token_in.matched && hit)
        begin
            token_next.matched = 1'b1;
            token_next.grant   = rule_reg.grant;
            token_next.index   = mac_pkg::INDEX_W'(CELL_INDEX);
        end
    end

    // rule storage
    always_ff @(posedge clk)
    begin
        if (wr_hit)
        begin
            rule_reg <= wr_rule;
        end
    end

    // token stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            token_reg <= '0;
        end
        else if (ctrl.advance)
        begin
            token_reg <= token_next;
        end
    end

    assign token_out = token_reg;

endmodule

// ===== rtl/core/mac_chain.sv =====
`timescale 1ns / 1ps
// mac_chain: row of rule cells, a token moves one cell per cycle while the chain advances
// depends on mac_pkg and mac_cell
module mac_chain #(
    parameter int ENTRIES = mac_pkg::ENTRIES_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  mac_pkg::chain_ctrl_t         ctrl,
    input  mac_pkg::rule_t               wr_rule,
    input  logic [mac_pkg::COUNT_W-1:0]  rule_count,
    input  mac_pkg::token_t              token_in,
    output mac_pkg::token_t              token_out
);

    mac_pkg::token_t link [0:ENTRIES];

    assign link[0]   = token_in;
    assign token_out = link[ENTRIES];

    // cells in table order, lowest index first
    for (genvar k = 0; k < ENTRIES; k++)
    begin : g_cell
        mac_cell #(
            .ENTRIES    (ENTRIES),
            .CELL_INDEX (k)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .wr_rule    (wr_rule),
            .rule_count (rule_count),
            .token_in   (link[k]),
            .token_out  (link[k+1])
        );
    end

endmodule

// ===== rtl/core/masked_address_access_check.sv =====
`timescale 1ns / 1ps
// masked_address_access_check: top level, request/response channels, APB register, result stage
// depends on mac_pkg, mac_if and mac_chain
//
//  channel  | direction | carries
//  ---------+-----------+----------------------------------------------
//  req      | in        | rule write or packet check beat
//  rsp      | out       | verdict beat, one per packet check
//  apb      | in        | rule_count register at byte address 0
//
// a write beat updates the addressed cell at the accepting edge
// a check beat walks the chain of ENTRIES cells, one cell per cycle while the chain advances;
// a new check is taken only once the verdict of the last is captured in the result register
// the result register holds a waiting verdict while the next beat enters the chain
// a stalled rsp freezes the chain once the token reaches the last cell
// reset clears control state and rule_count; rules must be written before use
module masked_address_access_check #(
    parameter int ENTRIES = mac_pkg::ENTRIES_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    mac_req_if.sink                         req,
    mac_rsp_if.source                       rsp,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mac_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [mac_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [mac_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);

    logic [mac_pkg::COUNT_W-1:0]  rule_count_reg;
    logic                         busy_reg;
    logic                         busy_next;
    logic                         rsp_valid_reg;
    logic                         permitted_reg;
    logic                         matched_reg;
    logic [mac_pkg::INDEX_W-1:0]  match_index_reg;

    mac_pkg::chain_ctrl_t         ctrl;
    mac_pkg::rule_t               wr_rule;
    mac_pkg::token_t              token_in;
    mac_pkg::token_t              token_last;
    logic                         accept;
    logic                         check_beat;
    logic                         capture;

    // apb register, rule_count at byte address 0
    assign pready = 1'b1;
    assign prdata = mac_pkg::APB_DATA_W'(rule_count_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rule_count_reg <= '0;
        end
        else if (psel && penable && pwrite && (paddr == mac_pkg::REG_RULE_COUNT))
        begin
            rule_count_reg <= pwdata[mac_pkg::COUNT_W-1:0];
        end
    end

    // request handshake
    assign capture    = token_last.valid && (!rsp_valid_reg || rsp.ready);
    assign req.ready  = !busy_reg || capture;
    assign accept     = req.valid && req.ready;
    assign check_beat = accept && (req.command == mac_pkg::CMD_CHECK);

    // chain control
    assign ctrl.advance  = !(token_last.valid && rsp_valid_reg && !rsp.ready);
    assign ctrl.wr_en    = accept && (req.command == mac_pkg::CMD_WRITE);
    assign ctrl.wr_index = req.rule_index;

    assign wr_rule.src_value  = req.rule_source;
    assign wr_rule.src_mask   = req.rule_source_mask;
    assign wr_rule.dst_value  = req.rule_dest;
    assign wr_rule.dst_mask   = req.rule_dest_mask;
    assign wr_rule.check_dest = req.rule_check_dest;
    assign wr_rule.grant      = req.rule_grant;

    assign token_in.valid   = check_beat;
    assign token_in.src     = req.packet_source;
    assign token_in.dst     = req.packet_dest;
    assign token_in.matched = 1'b0;
    assign token_in.grant   = 1'b0;
    assign token_in.index   = '0;

    mac_chain #(
        .ENTRIES    (ENTRIES)
    ) u_chain (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .wr_rule    (wr_rule),
        .rule_count (rule_count_reg),
        .token_in   (token_in),
        .token_out  (token_last)
    );

    // one packet in the chain at a time
    always_comb
    begin
        busy_next = busy_reg;
        if (capture)
        begin
            busy_next = 1'b0;
        end
        if (check_beat)
        begin
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            if (capture)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, unmatched tokens carry zeros
    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            permitted_reg   <= token_last.matched && token_last.grant;
            matched_reg     <= token_last.matched;
            match_index_reg <= token_last.matched ? token_last.index : '0;
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.permitted   = permitted_reg;
    assign rsp.matched     = matched_reg;
    assign rsp.match_index = match_index_reg;

endmodule

// ===== rtl/core/mac_checker.sv =====
`timescale 1ns / 1ps
// mac_checker: port-level assertions for the access check, bound to the top level
// depends on mac_pkg, mac_if and masked_address_access_check_assert.svh
`include "masked_address_access_check_assert.svh"

module mac_checker #(
    parameter int ENTRIES = mac_pkg::ENTRIES_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    mac_req_if.sink    req,
    mac_rsp_if.source  rsp,
    input  logic       pready
);

    logic req_check;
    logic idx_in_range;

    assign req_check    = req.valid && req.ready && (req.command == mac_pkg::CMD_CHECK);
    assign idx_in_range = (ENTRIES >= 16) || (int'(rsp.match_index) < ENTRIES);

    // a stalled verdict beat holds
    `MAC_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp.valid && !rsp.ready, rsp.valid && $stable(rsp.permitted) && $stable(rsp.matched) && $stable(rsp.match_index))

    // a miss reports deny at index zero
    `MAC_ASSERT_NOW(a_miss_zero, clk, rst_n, rsp.valid && !rsp.matched, !rsp.permitted && (rsp.match_index == '0))

    // a hit points inside the table
    `MAC_ASSERT_NOW(a_hit_range, clk, rst_n, rsp.valid && rsp.matched, idx_in_range)

    // a packet occupies the chain, no beat follows right behind it
    `MAC_ASSERT_NEXT(a_check_blocks, clk, rst_n, req_check && (ENTRIES > 1), !req.ready && pready)

endmodule

bind masked_address_access_check mac_checker #(
    .ENTRIES (ENTRIES)
) u_mac_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (req),
    .rsp    (rsp),
    .pready (pready)
);

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// tb_top: self-checking bench for the masked address access check, rule writes and packet checks
// depends on mac_pkg, mac_if and masked_address_access_check; verdicts predicted in a scoreboard
module tb_top;

    localparam int ENTRIES       = mac_pkg::ENTRIES_DEFAULT;
    localparam int SETTLE_CYCLES = ENTRIES + 24;
    localparam int STALL_LIMIT   = 4000;
    localparam int PHASE_ITEMS   = 130;
    localparam int NUM_PHASES    = 9;

    // one request beat as seen on the bus
    typedef struct {
        logic                        command;
        logic [mac_pkg::INDEX_W-1:0] rule_index;
        logic [mac_pkg::ADDR_W-1:0]  rule_source;
        logic [mac_pkg::ADDR_W-1:0]  rule_source_mask;
        logic [mac_pkg::ADDR_W-1:0]  rule_dest;
        logic [mac_pkg::ADDR_W-1:0]  rule_dest_mask;
        logic                        rule_check_dest;
        logic                        rule_grant;
        logic [mac_pkg::ADDR_W-1:0]  packet_source;
        logic [mac_pkg::ADDR_W-1:0]  packet_dest;
    } access_item_t;

    // one verdict beat
    typedef struct {
        logic                        permitted;
        logic                        matched;
        logic [mac_pkg::INDEX_W-1:0] match_index;
    } verdict_t;

    // rule table copy, first-match search and the queue of verdicts still owed
    class access_scoreboard;
        mac_pkg::rule_t              rules [ENTRIES];
        logic [mac_pkg::COUNT_W-1:0] rule_count;
        verdict_t                    verdicts_due [$];
        int                          errors;

        function new();
            rule_count = '0;
            errors     = 0;
        endfunction

        function void set_count(logic [mac_pkg::COUNT_W-1:0] value);
            rule_count = value;
        endfunction

        // counts beyond the table are clamped to its size
        function int search_limit();
            return (rule_count > ENTRIES) ? ENTRIES : int'(rule_count);
        endfunction

        function bit addr_hits(logic [mac_pkg::ADDR_W-1:0] addr,
                               logic [mac_pkg::ADDR_W-1:0] value,
                               logic [mac_pkg::ADDR_W-1:0] mask);
            return (addr & ~mask) == value;
        endfunction

        function void note_item(access_item_t it);
            verdict_t v;
            int       lim;
            if (it.command == mac_pkg::CMD_WRITE)
            begin
                // positions past the table are dropped
                if (int'(it.rule_index) < ENTRIES)
                begin
                    rules[it.rule_index] = '{src_value: it.rule_source,
                                             src_mask: it.rule_source_mask,
                                             dst_value: it.rule_dest,
                                             dst_mask: it.rule_dest_mask,
                                             check_dest: it.rule_check_dest,
                                             grant: it.rule_grant};
                end
                return;
            end
            v   = '{1'b0, 1'b0, '0};
            lim = search_limit();
            // lowest index wins
            for (int i = 0; i < lim; i++)
            begin
                if (!v.matched
                    && addr_hits(it.packet_source, rules[i].src_value, rules[i].src_mask)
                    && (!rules[i].check_dest
                        || addr_hits(it.packet_dest, rules[i].dst_value, rules[i].dst_mask)))
                begin
                    v = '{rules[i].grant, 1'b1, mac_pkg::INDEX_W'(i)};
                end
            end
            verdicts_due.push_back(v);
        endfunction

        function void check_result(verdict_t got);
            verdict_t want;
            if (verdicts_due.size() == 0)
            begin
                $error("verdict beat with none outstanding: permitted %0d matched %0d index %0d",
                       got.permitted, got.matched, got.match_index);
                errors++;
                return;
            end
            want = verdicts_due.pop_front();
            if (got.permitted !== want.permitted)
            begin
                $error("permitted: expected %0d, actual %0d", want.permitted, got.permitted);
                errors++;
            end
            if (got.matched !== want.matched)
            begin
                $error("matched: expected %0d, actual %0d", want.matched, got.matched);
                errors++;
            end
            if (got.match_index !== want.match_index)
            begin
                $error("match_index: expected %0d, actual %0d", want.match_index,
                       got.match_index);
                errors++;
            end
        endfunction
    endclass

    logic                           clk;
    logic                           rst_n;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [mac_pkg::APB_ADDR_W-1:0] paddr;
    logic [mac_pkg::APB_DATA_W-1:0] pwdata;
    logic [mac_pkg::APB_DATA_W-1:0] prdata;
    logic                           pready;

    mac_req_if req_ch ();
    mac_rsp_if rsp_ch ();

    access_scoreboard sb;
    int send_idle_pct;
    int stall_pct;
    int quiet_cycles = 0;
    int phase_counts [NUM_PHASES] = '{16, 1, 31, 0, 8, 16, 5, 12, 16};

    masked_address_access_check #(
        .ENTRIES (ENTRIES)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // receiver back-pressure
    always @(negedge clk)
    begin
        rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    // monitor: verdicts checked before the request of the same edge is noted
    always @(posedge clk)
    begin : monitor
        access_item_t seen;
        bit           moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                sb.check_result(verdict_t'{rsp_ch.permitted, rsp_ch.matched,
                                           rsp_ch.match_index});
                moved = 1'b1;
            end
            if (req_ch.valid && req_ch.ready)
            begin
                seen = '{req_ch.command, req_ch.rule_index, req_ch.rule_source,
                         req_ch.rule_source_mask, req_ch.rule_dest, req_ch.rule_dest_mask,
                         req_ch.rule_check_dest, req_ch.rule_grant, req_ch.packet_source,
                         req_ch.packet_dest};
                sb.note_item(seen);
                moved = 1'b1;
            end
            if (psel && penable && pwrite && pready)
                moved = 1'b1;
            // watchdog
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // one request beat, with random gaps ahead of it
    task automatic send_item(access_item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid = 1'b0;
            @(negedge clk);
        end
        req_ch.command          = it.command;
        req_ch.rule_index       = it.rule_index;
        req_ch.rule_source      = it.rule_source;
        req_ch.rule_source_mask = it.rule_source_mask;
        req_ch.rule_dest        = it.rule_dest;
        req_ch.rule_dest_mask   = it.rule_dest_mask;
        req_ch.rule_check_dest  = it.rule_check_dest;
        req_ch.rule_grant       = it.rule_grant;
        req_ch.packet_source    = it.packet_source;
        req_ch.packet_dest      = it.packet_dest;
        req_ch.valid            = 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!req_ch.ready);
        @(negedge clk);
    endtask

    // hold the request side until every verdict is back
    task automatic drain_verdicts();
        req_ch.valid = 1'b0;
        while (sb.verdicts_due.size() != 0)
            @(negedge clk);
    endtask

    // register write only while the block is idle
    task automatic write_rule_count(logic [mac_pkg::COUNT_W-1:0] value);
        drain_verdicts();
        repeat (SETTLE_CYCLES) @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = mac_pkg::REG_RULE_COUNT;
        pwdata  = mac_pkg::APB_DATA_W'(value);
        @(negedge clk);
        penable = 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        sb.set_count(value);
    endtask

    function automatic access_item_t random_fields();
        access_item_t it;
        it.command          = 1'($urandom);
        it.rule_index       = mac_pkg::INDEX_W'($urandom);
        it.rule_source      = mac_pkg::ADDR_W'($urandom);
        it.rule_source_mask = mac_pkg::ADDR_W'($urandom);
        it.rule_dest        = mac_pkg::ADDR_W'($urandom);
        it.rule_dest_mask   = mac_pkg::ADDR_W'($urandom);
        it.rule_check_dest  = 1'($urandom);
        it.rule_grant       = 1'($urandom);
        it.packet_source    = mac_pkg::ADDR_W'($urandom);
        it.packet_dest      = mac_pkg::ADDR_W'($urandom);
        return it;
    endfunction

    // masks from exact to wildcard, with sparse and dense mixes
    function automatic logic [mac_pkg::ADDR_W-1:0] random_mask();
        case ($urandom_range(4))
            0:       return '0;
            1:       return '1;
            2:       return mac_pkg::ADDR_W'($urandom);
            3:       return mac_pkg::ADDR_W'($urandom & $urandom & $urandom);
            default: return mac_pkg::ADDR_W'($urandom | $urandom | $urandom);
        endcase
    endfunction

    // mostly matchable rules: stored value clear under the don't-care bits
    function automatic access_item_t rule_write();
        access_item_t it;
        it                  = random_fields();
        it.command          = mac_pkg::CMD_WRITE;
        it.rule_source_mask = random_mask();
        it.rule_dest_mask   = random_mask();
        if ($urandom_range(7) != 0)
            it.rule_source &= ~it.rule_source_mask;
        if ($urandom_range(7) != 0)
            it.rule_dest &= ~it.rule_dest_mask;
        return it;
    endfunction

    // most packets aimed at a live rule, the rest random
    function automatic access_item_t packet_check();
        access_item_t   it;
        mac_pkg::rule_t r;
        int             lim;
        it         = random_fields();
        it.command = mac_pkg::CMD_CHECK;
        lim        = sb.search_limit();
        if (lim > 0 && $urandom_range(9) < 7)
        begin
            r = sb.rules[$urandom_range(lim - 1)];
            it.packet_source = (r.src_value & ~r.src_mask) | (it.packet_source & r.src_mask);
            if ($urandom_range(4) != 0)
                it.packet_dest = (r.dst_value & ~r.dst_mask) | (it.packet_dest & r.dst_mask);
        end
        return it;
    endfunction

    function automatic access_item_t check_of(logic [mac_pkg::ADDR_W-1:0] src,
                                              logic [mac_pkg::ADDR_W-1:0] dst);
        access_item_t it;
        it               = random_fields();
        it.command       = mac_pkg::CMD_CHECK;
        it.packet_source = src;
        it.packet_dest   = dst;
        return it;
    endfunction

    // hand-picked rules at the edges of the table, random ones between
    function automatic access_item_t directed_rule(int idx);
        access_item_t it;
        it            = rule_write();
        it.rule_index = mac_pkg::INDEX_W'(idx);
        case (idx)
            0:
            begin
                // exact source and destination
                {it.rule_source, it.rule_source_mask} = {16'hFFFF, 16'h0000};
                {it.rule_dest, it.rule_dest_mask}     = {16'h0000, 16'h0000};
                {it.rule_check_dest, it.rule_grant}   = 2'b11;
            end
            1:
            begin
                // value set under don't-care bits, can never hit
                {it.rule_source, it.rule_source_mask} = {16'h00FF, 16'h00FF};
                {it.rule_check_dest, it.rule_grant}   = 2'b01;
            end
            2:
            begin
                {it.rule_source, it.rule_source_mask} = {16'h1200, 16'h00FF};
                {it.rule_dest, it.rule_dest_mask}     = {16'hABCD, 16'h0000};
                {it.rule_check_dest, it.rule_grant}   = 2'b11;
            end
            3:
            begin
                // same source, destination ignored, denies
                {it.rule_source, it.rule_source_mask} = {16'h1200, 16'h00FF};
                {it.rule_check_dest, it.rule_grant}   = 2'b00;
            end
            ENTRIES - 1:
            begin
                // catch-all at the bottom
                {it.rule_source, it.rule_source_mask} = {16'h0000, 16'hFFFF};
                {it.rule_dest, it.rule_dest_mask}     = {16'h0000, 16'hFFFF};
                {it.rule_check_dest, it.rule_grant}   = 2'b11;
            end
            default:
            begin
            end
        endcase
        return it;
    endfunction

    // stimulus
    initial
    begin
        sb                      = new();
        send_idle_pct           = 0;
        stall_pct               = 0;
        rst_n                   = 1'b0;
        psel                    = 1'b0;
        penable                 = 1'b0;
        pwrite                  = 1'b0;
        paddr                   = '0;
        pwdata                  = '0;
        req_ch.valid            = 1'b0;
        req_ch.command          = mac_pkg::CMD_WRITE;
        req_ch.rule_index       = '0;
        req_ch.rule_source      = '0;
        req_ch.rule_source_mask = '0;
        req_ch.rule_dest        = '0;
        req_ch.rule_dest_mask   = '0;
        req_ch.rule_check_dest  = 1'b0;
        req_ch.rule_grant       = 1'b0;
        req_ch.packet_source    = '0;
        req_ch.packet_dest      = '0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // empty search: no match
        send_item(check_of(16'h0000, 16'hFFFF));

        // fill the whole table before any rule is searched
        for (int i = 0; i < ENTRIES; i++)
            send_item(directed_rule(i));
        write_rule_count(mac_pkg::COUNT_W'(ENTRIES));

        send_item(check_of(16'hFFFF, 16'h0000));
        send_item(check_of(16'hFFFF, 16'h0001));
        send_item(check_of(16'h12A5, 16'hABCD));
        send_item(check_of(16'h1234, 16'hABCC));
        send_item(check_of(16'h00FF, 16'hFFFF));
        send_item(check_of(16'h0000, 16'h0000));

        // random phases over count settings and idle and stall patterns
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            send_idle_pct = 0;
            stall_pct     = 0;
            write_rule_count(mac_pkg::COUNT_W'(phase_counts[p]));
            case (p % 4)
                1:       send_idle_pct = 77;
                2:       stall_pct = 77;
                3:
                begin
                    send_idle_pct = 36;
                    stall_pct     = 36;
                end
                default: ;
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (p == 2 && n == PHASE_ITEMS / 2)
                    drain_verdicts();
                if ($urandom_range(4) == 0)
                    send_item(rule_write());
                else
                    send_item(packet_check());
            end
        end

        // wind down
        drain_verdicts();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
